### hw/rtl/vsls_pkg.sv
// Shared types and constants for the scan-line list sequencer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package vsls_pkg;

   localparam int FP_W        = 8;
   localparam int SYNC_W      = 8;
   localparam int BP_W        = 8;
   localparam int ACTIVE_W    = 10;
   localparam int WORDS_W     = 9;
   localparam int SYNC_END_W  = 9;
   localparam int BLANK_END_W = 10;
   localparam int LINE_W      = 11;
   localparam int FRAME_W     = 32;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 56;
   localparam int RSP_USER_W  = 2;

   localparam logic [FP_W-1:0]     FP_RESET     = 8'd10;
   localparam logic [SYNC_W-1:0]   SYNC_RESET   = 8'd2;
   localparam logic [BP_W-1:0]     BP_RESET     = 8'd33;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 10'd480;
   localparam logic [WORDS_W-1:0]  WORDS_RESET  = 9'd160;
   localparam logic [LINE_W-1:0]   LINE_RESET   = 11'd2;

   localparam logic [WORDS_W-1:0] BLANK_LIST_WORDS = 9'd7;
   localparam logic [WORDS_W-1:0] ACTIVE_CMD_WORDS = 9'd9;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRONT_PORCH  = 3'd0,
      CSR_SYNC         = 3'd1,
      CSR_BACK_PORCH   = 3'd2,
      CSR_ACTIVE       = 3'd3,
      CSR_PIXEL_WORDS  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_VSYNC_ON   = 2'd0,
      KIND_VSYNC_OFF  = 2'd1,
      KIND_ACTIVE_CMD = 2'd2,
      KIND_PIXELS     = 2'd3
   } list_kind_type;

   typedef struct packed {
      logic [FP_W-1:0]     front_porch_lines;
      logic [SYNC_W-1:0]   sync_lines;
      logic [BP_W-1:0]     back_porch_lines;
      logic [ACTIVE_W-1:0] active_lines;
      logic [WORDS_W-1:0]  pixel_line_words;
   } timing_type;

   typedef struct packed {
      logic                finished_channel;
      list_kind_type       list_kind;
      logic [ACTIVE_W-1:0] active_line;
      logic [WORDS_W-1:0]  transfer_words;
      logic                frame_end;
      logic [FRAME_W-1:0]  frame_tally;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/vsls_csr.sv
// Timing register file of the scan-line list sequencer.
// Depends on vsls_pkg for the register indexes and the timing struct.
`default_nettype none

module vsls_csr (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [vsls_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [vsls_pkg::CSR_DATA_W-1:0]   csr_data,
   output vsls_pkg::timing_type              timing
);

   vsls_pkg::timing_type timing_ff;
   vsls_pkg::timing_type timing_in;
   logic                 write_en;

   assign csr_ready = 1'b1;
   assign write_en  = csr_valid && csr_ready;
   assign timing    = timing_ff;

   always_comb begin
      timing_in = timing_ff;
      if (write_en) begin
         unique case (vsls_pkg::csr_index_type'(csr_index))
            vsls_pkg::CSR_FRONT_PORCH: begin
               timing_in.front_porch_lines = csr_data[vsls_pkg::FP_W-1:0];
            end
            vsls_pkg::CSR_SYNC: begin
               timing_in.sync_lines = csr_data[vsls_pkg::SYNC_W-1:0];
            end
            vsls_pkg::CSR_BACK_PORCH: begin
               timing_in.back_porch_lines = csr_data[vsls_pkg::BP_W-1:0];
            end
            vsls_pkg::CSR_ACTIVE: begin
               timing_in.active_lines = csr_data[vsls_pkg::ACTIVE_W-1:0];
            end
            vsls_pkg::CSR_PIXEL_WORDS: begin
               timing_in.pixel_line_words = csr_data[vsls_pkg::WORDS_W-1:0];
            end
            default: begin
               timing_in = timing_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.front_porch_lines <= vsls_pkg::FP_RESET;
         timing_ff.sync_lines        <= vsls_pkg::SYNC_RESET;
         timing_ff.back_porch_lines  <= vsls_pkg::BP_RESET;
         timing_ff.active_lines      <= vsls_pkg::ACTIVE_RESET;
         timing_ff.pixel_line_words  <= vsls_pkg::WORDS_RESET;
      end else begin
         timing_ff <= timing_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/vsls_core.sv
// Line sequencing state and list selection of the scan-line list sequencer.
// Depends on vsls_pkg for the timing and result structs and the list kinds.
`default_nettype none

module vsls_core (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   step,
   input  vsls_pkg::timing_type  timing,
   output vsls_pkg::result_type  result
);

   logic [vsls_pkg::LINE_W-1:0]      line_counter_ff, line_counter_in;
   logic                             cmdlist_posted_ff, cmdlist_posted_in;
   logic                             pong_next_ff;
   logic [vsls_pkg::FRAME_W-1:0]     frame_count_ff, frame_count_in;

   logic [vsls_pkg::SYNC_END_W-1:0]  sync_end;
   logic [vsls_pkg::BLANK_END_W-1:0] blank_end;
   logic [vsls_pkg::LINE_W-1:0]      total;
   logic [vsls_pkg::LINE_W-1:0]      line_offset;
   logic [vsls_pkg::LINE_W:0]        line_inc;
   logic                             in_sync;
   logic                             in_blank;
   logic                             wrap;

   assign sync_end  = {1'b0, timing.front_porch_lines} + {1'b0, timing.sync_lines};
   assign blank_end = {1'b0, sync_end} + {2'b00, timing.back_porch_lines};
   assign total     = {1'b0, blank_end} + {1'b0, timing.active_lines};

   assign in_sync  = (line_counter_ff >= {3'b000, timing.front_porch_lines})
                  && (line_counter_ff < {2'b00, sync_end});
   assign in_blank = line_counter_ff < {1'b0, blank_end};

   assign line_offset = line_counter_ff - {1'b0, blank_end};
   assign line_inc    = {1'b0, line_counter_ff} + {{vsls_pkg::LINE_W{1'b0}}, 1'b1};
   assign wrap        = line_inc >= {1'b0, total};

   always_comb begin
      result.finished_channel = pong_next_ff;
      result.active_line      = '0;
      cmdlist_posted_in       = cmdlist_posted_ff;
      priority if (in_sync) begin
         result.list_kind      = vsls_pkg::KIND_VSYNC_ON;
         result.transfer_words = vsls_pkg::BLANK_LIST_WORDS;
      end else if (in_blank) begin
         result.list_kind      = vsls_pkg::KIND_VSYNC_OFF;
         result.transfer_words = vsls_pkg::BLANK_LIST_WORDS;
      end else if (!cmdlist_posted_ff) begin
         result.list_kind      = vsls_pkg::KIND_ACTIVE_CMD;
         result.transfer_words = vsls_pkg::ACTIVE_CMD_WORDS;
         cmdlist_posted_in     = 1'b1;
      end else begin
         result.list_kind      = vsls_pkg::KIND_PIXELS;
         result.transfer_words = timing.pixel_line_words;
         result.active_line    = line_offset[vsls_pkg::ACTIVE_W-1:0];
         cmdlist_posted_in     = 1'b0;
      end

      line_counter_in  = line_counter_ff;
      frame_count_in   = frame_count_ff;
      result.frame_end = 1'b0;
      if (!cmdlist_posted_in) begin
         if (wrap) begin
            line_counter_in  = '0;
            frame_count_in   = frame_count_ff + 32'd1;
            result.frame_end = 1'b1;
         end else begin
            line_counter_in = line_inc[vsls_pkg::LINE_W-1:0];
         end
      end
      result.frame_tally = frame_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_counter_ff   <= vsls_pkg::LINE_RESET;
         cmdlist_posted_ff <= 1'b0;
         pong_next_ff      <= 1'b0;
         frame_count_ff    <= '0;
      end else if (step) begin
         line_counter_ff   <= line_counter_in;
         cmdlist_posted_ff <= cmdlist_posted_in;
         pong_next_ff      <= !pong_next_ff;
         frame_count_ff    <= frame_count_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/video_scanline_list_sequencer.sv
// Accepted items wait in the input register; their results in the result register.
// Throughput: one item per cycle; the input register and the result register
// each move on as soon as the next stage can take their item.
// Items with transfer_done low are dropped in the input register and give no result.
// Reset is synchronous and active high: registers return to their default timing,
// the line counter to 2, the channel to ping and the frame count to zero.
`default_nettype none

module video_scanline_list_sequencer (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // [0] transfer_done, [7:1] zero
   input  wire  [vsls_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // [0] finished_channel, [10:1] active_line, [19:11] transfer_words,
   // [51:20] frame_tally, [55:52] zero
   output logic [vsls_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [1:0] list_kind
   output logic [vsls_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                             rsp_tlast,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [vsls_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  [vsls_pkg::CSR_DATA_W-1:0]  csr_data
);

   vsls_pkg::timing_type timing;
   vsls_pkg::result_type core_result;
   vsls_pkg::result_type rsp_result_ff;

   logic in_valid_ff, in_valid_in;
   logic in_done_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic in_fire;
   logic step;
   logic req_fire;

   vsls_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .timing    (timing)
   );

   vsls_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .timing (timing),
      .result (core_result)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign in_fire    = in_valid_ff && (!in_done_ff || out_free);
   assign step       = in_fire && in_done_ff;
   assign req_tready = !in_valid_ff || in_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (in_fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_done_ff <= req_tdata[0];
      end
      if (step) begin
         rsp_result_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        rsp_result_ff.frame_tally,
                        rsp_result_ff.transfer_words,
                        rsp_result_ff.active_line,
                        rsp_result_ff.finished_channel};
   assign rsp_tuser  = rsp_result_ff.list_kind;
   assign rsp_tlast  = rsp_result_ff.frame_end;

endmodule

`default_nettype wire

### hw/rtl/vsls_checker.sv
// Port-level checker for the scan-line list sequencer, bound to the top level.
// Depends on vsls_pkg for the list kinds and field widths.
`default_nettype none

module vsls_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire [vsls_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire [vsls_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input wire                              rsp_tlast
);

   logic                          rsp_fire;
   logic                          channel_ff;
   logic [vsls_pkg::FRAME_W-1:0]  frames_ff;
   logic [vsls_pkg::FRAME_W-1:0]  frames_seen;

   assign rsp_fire    = rsp_tvalid && rsp_tready;
   assign frames_seen = rsp_tdata[51:20];

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff <= 1'b0;
         frames_ff  <= '0;
      end else if (rsp_fire) begin
         channel_ff <= !channel_ff;
         frames_ff  <= frames_seen;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_channel_alternates: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> rsp_tdata[0] == channel_ff)
      else $error("finished channel did not alternate");

   a_frame_count: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> frames_seen == (rsp_tlast ? frames_ff + 32'd1 : frames_ff))
      else $error("frame count does not follow frame end");

   a_frame_end_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser != vsls_pkg::KIND_ACTIVE_CMD)
      else $error("frame end on a command list item");

   a_line_only_pixels: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != vsls_pkg::KIND_PIXELS |-> rsp_tdata[10:1] == 10'd0)
      else $error("active line set on a non-pixel item");

endmodule

bind video_scanline_list_sequencer vsls_checker u_vsls_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for video_scanline_list_sequencer: random and directed
// transfer-done items, timing register writes between phases, scoreboard predictor.
// Depends on vsls_pkg and the sequencer RTL only.
`timescale 1ns / 100ps

module testbench;

   localparam int LIMIT_CYCLES   = 500000;
   localparam int RANDOM_TARGET  = 900;
   localparam int SETTLE_CYCLES  = 4;
   localparam int CSR_INDEX_LAST = (1 << vsls_pkg::CSR_INDEX_W) - 1;

   typedef logic [vsls_pkg::CSR_DATA_W-1:0]  csr_word_type;
   typedef logic [vsls_pkg::CSR_INDEX_W-1:0] csr_addr_type;

   class scanline_scoreboard;
      logic [vsls_pkg::FP_W-1:0]     front_porch;
      logic [vsls_pkg::SYNC_W-1:0]   sync_width;
      logic [vsls_pkg::BP_W-1:0]     back_porch;
      logic [vsls_pkg::ACTIVE_W-1:0] visible_lines;
      logic [vsls_pkg::WORDS_W-1:0]  line_words;
      logic [vsls_pkg::LINE_W-1:0]   line_count;
      logic                          cmd_list_sent;
      logic                          pong_turn;
      logic [vsls_pkg::FRAME_W-1:0]  frames_done;
      vsls_pkg::result_type          pending_lists[$];
      int                            failures;
      int                            lists_checked;
      int                            frame_ends_seen;
      int                            kinds_seen[4];

      function new();
         front_porch   = vsls_pkg::FP_RESET;
         sync_width    = vsls_pkg::SYNC_RESET;
         back_porch    = vsls_pkg::BP_RESET;
         visible_lines = vsls_pkg::ACTIVE_RESET;
         line_words    = vsls_pkg::WORDS_RESET;
         line_count    = vsls_pkg::LINE_RESET;
         cmd_list_sent = 1'b0;
         pong_turn     = 1'b0;
         frames_done   = '0;
         failures      = 0;
         lists_checked = 0;
         frame_ends_seen = 0;
         foreach (kinds_seen[k]) kinds_seen[k] = 0;
      endfunction

      function void write_timing_register(csr_addr_type index, csr_word_type data);
         unique case (index)
            vsls_pkg::CSR_FRONT_PORCH: front_porch   = data[vsls_pkg::FP_W-1:0];
            vsls_pkg::CSR_SYNC:        sync_width    = data[vsls_pkg::SYNC_W-1:0];
            vsls_pkg::CSR_BACK_PORCH:  back_porch    = data[vsls_pkg::BP_W-1:0];
            vsls_pkg::CSR_ACTIVE:      visible_lines = data[vsls_pkg::ACTIVE_W-1:0];
            vsls_pkg::CSR_PIXEL_WORDS: line_words    = data[vsls_pkg::WORDS_W-1:0];
            default: ;
         endcase
      endfunction

      // Works out the next list to post for one accepted item; an item with transfer_done low posts none.
      function void note_transfer_done(logic done);
         vsls_pkg::result_type next_list;
         int unsigned          sync_end;
         int unsigned          blank_end;
         int unsigned          frame_total;
         int unsigned          advanced;
         if (!done) return;
         next_list = '0;
         next_list.finished_channel = pong_turn;
         pong_turn = ~pong_turn;
         sync_end    = front_porch;
         sync_end    = sync_end + sync_width;
         blank_end   = sync_end + back_porch;
         frame_total = blank_end + visible_lines;
         if (line_count >= front_porch && line_count < sync_end) begin
            next_list.list_kind      = vsls_pkg::KIND_VSYNC_ON;
            next_list.transfer_words = vsls_pkg::BLANK_LIST_WORDS;
         end else if (line_count < blank_end) begin
            next_list.list_kind      = vsls_pkg::KIND_VSYNC_OFF;
            next_list.transfer_words = vsls_pkg::BLANK_LIST_WORDS;
         end else if (!cmd_list_sent) begin
            next_list.list_kind      = vsls_pkg::KIND_ACTIVE_CMD;
            next_list.transfer_words = vsls_pkg::ACTIVE_CMD_WORDS;
            cmd_list_sent = 1'b1;
         end else begin
            advanced = line_count - blank_end;
            next_list.list_kind      = vsls_pkg::KIND_PIXELS;
            next_list.transfer_words = line_words;
            next_list.active_line    = advanced[vsls_pkg::ACTIVE_W-1:0];
            cmd_list_sent = 1'b0;
         end
         if (!cmd_list_sent) begin
            advanced = line_count + 1;
            if (advanced >= frame_total) begin
               advanced = 0;
               frames_done = frames_done + 1;
               next_list.frame_end = 1'b1;
            end
            line_count = advanced[vsls_pkg::LINE_W-1:0];
         end
         next_list.frame_tally = frames_done;
         pending_lists.push_back(next_list);
      endfunction

      function void check_posted_list(vsls_pkg::result_type got);
         vsls_pkg::result_type want;
         if (pending_lists.size() == 0) begin
            if (failures < 10)
               $display("ERROR: list posted with none pending: ch %0d kind %0d line %0d",
                        got.finished_channel, got.list_kind, got.active_line);
            failures++;
            return;
         end
         want = pending_lists.pop_front();
         lists_checked++;
         if (got.finished_channel !== want.finished_channel ||
             got.list_kind !== want.list_kind ||
             got.active_line !== want.active_line ||
             got.transfer_words !== want.transfer_words ||
             got.frame_end !== want.frame_end ||
             got.frame_tally !== want.frame_tally) begin
            if (failures < 10) begin
               $display("ERROR: list %0d mismatch", lists_checked);
               $display("  expected ch %0d kind %0d line %0d words %0d end %0d frames %0d",
                        want.finished_channel, want.list_kind,
                        want.active_line, want.transfer_words, want.frame_end,
                        want.frame_tally);
               $display("  actual   ch %0d kind %0d line %0d words %0d end %0d frames %0d",
                        got.finished_channel, got.list_kind, got.active_line,
                        got.transfer_words, got.frame_end, got.frame_tally);
            end
            failures++;
         end
         if (!$isunknown(got.list_kind)) kinds_seen[int'(got.list_kind)]++;
         if (got.frame_end === 1'b1) frame_ends_seen++;
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [vsls_pkg::REQ_DATA_W-1:0]  req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [vsls_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic [vsls_pkg::RSP_USER_W-1:0]  rsp_tuser;
   logic                             rsp_tlast;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [vsls_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [vsls_pkg::CSR_DATA_W-1:0]  csr_data;

   scanline_scoreboard board;
   int                 cycle_count;
   int                 stall_mode;
   int                 stall_step;
   int                 settings_used;

   video_scanline_list_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("ERROR: run exceeded %0d cycles", LIMIT_CYCLES);
         $display("testbench: FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ((stall_step % 7) < 4);
      endcase
      stall_step++;
   end

   always @(posedge clock) begin
      vsls_pkg::result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.finished_channel = rsp_tdata[0];
         got.active_line      = rsp_tdata[10:1];
         got.transfer_words   = rsp_tdata[19:11];
         got.frame_tally      = rsp_tdata[51:20];
         got.list_kind        = vsls_pkg::list_kind_type'(rsp_tuser);
         got.frame_end        = rsp_tlast;
         board.check_posted_list(got);
      end
   end

   // Leaves req_tvalid high; returns at the falling edge after acceptance.
   task automatic push_item(logic done);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(vsls_pkg::REQ_DATA_W-1){1'b0}}, done};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_transfer_done(done);
      @(negedge clock);
   endtask

   task automatic csr_put(csr_addr_type index, csr_word_type data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_timing_register(index, data);
      @(negedge clock);
   endtask

   task automatic load_timing(csr_word_type fp, csr_word_type sync,
                              csr_word_type bp, csr_word_type active,
                              csr_word_type words, bit stray_write);
      csr_put(vsls_pkg::CSR_FRONT_PORCH, fp);
      csr_put(vsls_pkg::CSR_SYNC, sync);
      if (stray_write)
         csr_put(csr_addr_type'($urandom_range(int'(vsls_pkg::CSR_PIXEL_WORDS) + 1,
                                               CSR_INDEX_LAST)),
                 csr_word_type'($urandom));
      csr_put(vsls_pkg::CSR_BACK_PORCH, bp);
      csr_put(vsls_pkg::CSR_ACTIVE, active);
      csr_put(vsls_pkg::CSR_PIXEL_WORDS, words);
      csr_valid <= 1'b0;
      @(negedge clock);
      settings_used++;
   endtask

   // Called with req_tvalid already low; always lets time pass.
   task automatic wait_for_lists();
      while (board.pending_lists.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic stream_transfers(int count, bit with_gaps, bit hold_midway);
      int sent;
      int burst_left;
      sent = 0;
      burst_left = $urandom_range(1, 16);
      while (sent < count) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (with_gaps) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(negedge clock);
            end
         end
         if ($urandom_range(0, 9) == 0) begin
            push_item(1'b0);
         end else begin
            push_item(1'b1);
            sent++;
            if (hold_midway && sent == count / 2) begin
               req_tvalid <= 1'b0;
               wait_for_lists();
            end
         end
         burst_left--;
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      int random_done;
      int phase;
      int count;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cycle_count = 0;
      stall_mode = 0;
      stall_step = 0;
      settings_used = 0;
      board = new();
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset timing first, with one item that carries no completion.
      push_item(1'b1);
      push_item(1'b0);
      push_item(1'b1);
      push_item(1'b1);
      req_tvalid <= 1'b0;
      wait_for_lists();

      // Short frame: every list kind, pixel line words at maximum, frame wraps.
      load_timing(1, 2, 1, 2, 511, 1'b0);
      stall_mode = 1;
      for (int i = 0; i < 13; i++) push_item(i != 6);
      req_tvalid <= 1'b0;
      wait_for_lists();

      // All line counts zero: counter lies at or beyond the total, every advance wraps.
      load_timing(0, 0, 0, 0, 0, 1'b0);
      stall_mode = 2;
      for (int i = 0; i < 6; i++) push_item(1'b1);
      req_tvalid <= 1'b0;
      wait_for_lists();

      random_done = 0;
      phase = 0;
      while (random_done < RANDOM_TARGET) begin
         case (phase)
            0: begin
               load_timing(10'h3FF, 10'h3FF, 10'h3FF, 1023, 511, 1'b1);
               count = 80;
            end
            1: begin
               load_timing(csr_word_type'(vsls_pkg::FP_RESET),
                           csr_word_type'(vsls_pkg::SYNC_RESET),
                           csr_word_type'(vsls_pkg::BP_RESET),
                           csr_word_type'(vsls_pkg::ACTIVE_RESET),
                           csr_word_type'(vsls_pkg::WORDS_RESET), 1'b0);
               count = 100;
            end
            2: begin
               load_timing(0, 1, 0, 1, 1, 1'b0);
               count = 40;
            end
            default: begin
               if (phase % 7 == 0) begin
                  load_timing(csr_word_type'($urandom), csr_word_type'($urandom),
                              csr_word_type'($urandom), csr_word_type'($urandom),
                              csr_word_type'($urandom), 1'b1);
                  count = 40;
               end else begin
                  load_timing({2'($urandom_range(0, 3)), 8'($urandom_range(0, 5))},
                              {2'($urandom_range(0, 3)), 8'($urandom_range(0, 4))},
                              {2'($urandom_range(0, 3)), 8'($urandom_range(0, 5))},
                              csr_word_type'($urandom_range(0, 8)),
                              csr_word_type'($urandom_range(0, 511)),
                              $urandom_range(0, 3) == 0);
                  count = $urandom_range(30, 70);
               end
            end
         endcase
         stall_mode = $urandom_range(0, 2);
         stream_transfers(count, (phase % 4) != 0, (phase % 3) == 1);
         wait_for_lists();
         random_done += count;
         phase++;
      end

      repeat (8) @(negedge clock);
      if (board.pending_lists.size() != 0) begin
         $display("ERROR: %0d lists never posted", board.pending_lists.size());
         board.failures++;
      end
      $display("Checked %0d posted lists over %0d timing settings, %0d frame ends.",
               board.lists_checked, settings_used, board.frame_ends_seen);
      $display("Kinds seen: vsync-on %0d, vsync-off %0d, command %0d, pixel %0d.",
               board.kinds_seen[0], board.kinds_seen[1], board.kinds_seen[2],
               board.kinds_seen[3]);
      if (board.failures == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("%0d mismatches in total", board.failures);
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/vsls_pkg.sv
hw/rtl/vsls_csr.sv
hw/rtl/vsls_core.sv
hw/rtl/video_scanline_list_sequencer.sv
hw/rtl/vsls_checker.sv
tb/testbench.sv
